@@ rtl/est_pkg.sv @@
// est_pkg: shared types, codes and sizes of the entity slot tracker
// no dependencies
`default_nettype none

package est_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int HASH_SHIFT = 4;
  localparam int ACC_W      = 66;

  localparam logic [31:0] TICK_RESET   = 32'd1;
  localparam logic [30:0] THRESH_RESET = 31'd655360;
  localparam logic [7:0]  STALE_RESET  = 8'd6;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_THRESH  = 2'd1;
  localparam logic [1:0] CFG_STALE   = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NULL     = 3'd3;
  localparam logic [2:0] ST_NOP      = 3'd4;
  localparam logic [2:0] ST_TICK     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_TICK,
    OP_CLEAR,
    OP_NOP,
    OP_NULL
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/est_front.sv @@
// est_front: accepts input beats, classifies them and queues them (two entries)
// depends on est_pkg
`default_nettype none

module est_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                enable_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [31:0]         key_i,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  output logic                     item_valid_o,
  output est_pkg::item_t           item_o,
  input  wire logic                item_pop_i
);

  est_pkg::item_t q_mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  est_pkg::item_t cls;
  logic           push;

  always_comb begin
    cls.key   = key_i;
    cls.pos_x = pos_x_i;
    cls.pos_y = pos_y_i;
    cls.pos_z = pos_z_i;
    case (mode_i)
      est_pkg::MODE_SAMPLE: begin
        if (!enable_i) cls.op = est_pkg::OP_NOP;
        else if (key_i == 32'd0) cls.op = est_pkg::OP_NULL;
        else cls.op = est_pkg::OP_SAMPLE;
      end
      est_pkg::MODE_TICK:  cls.op = enable_i ? est_pkg::OP_TICK : est_pkg::OP_NOP;
      est_pkg::MODE_CLEAR: cls.op = est_pkg::OP_CLEAR;
      default:             cls.op = est_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push, item_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/est_back.sv @@
// est_back: slot table engine (probe, update, teleport test, age-out sweep)
// and result register; depends on est_pkg
`default_nettype none

module est_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire est_pkg::item_t      item_i,
  output logic                     item_pop_o,
  input  wire logic [30:0]         thresh_i,
  input  wire logic [7:0]          stale_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               status_o,
  output logic [5:0]               slot_o,
  output logic                     teleport_o,
  output logic                     ready_res_o,
  output logic [6:0]               aged_out_o,
  output logic [6:0]               active_slots_o,
  output logic [31:0]              teleport_total_o
);

  localparam int IW = est_pkg::IDX_W;
  localparam int CW = est_pkg::CNT_W;
  localparam int AW = est_pkg::ACC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PRB_RD, S_PRB_CMP, S_UPD_RD, S_UPD, S_MUL, S_DRAIN, S_CMP, S_SWEEP, S_FIN
  } state_e;

  state_e          state_q;
  est_pkg::item_t  item_q;
  logic [IW-1:0]   idx_q, cnt_q, slot_q, p_idx_q;
  logic [est_pkg::SLOTS-1:0] occ_q, cv_q;
  logic [CW-1:0]   active_q, scnt_q, aged_q;
  logic [31:0]     tick_q, tcount_q;
  logic [32:0]     mag_q [3];
  logic [1:0]      axis_q, part_q, ppart_q;
  logic            pthr_q, pv_q, p_vld_q;
  logic [33:0]     prod_q;
  logic [AW-1:0]   acc_q, t2_q, addend;
  logic [2:0]      res_status_q;
  logic            res_tp_q, res_ready_q;

  logic            out_vld_q;
  logic [2:0]      out_status_q;
  logic [5:0]      out_slot_q;
  logic            out_tp_q, out_ready_q;
  logic [6:0]      out_aged_q, out_active_q;
  logic [31:0]     out_total_q;

  logic [31:0]     key_mem [est_pkg::SLOTS];
  logic [31:0]     seen_mem [est_pkg::SLOTS];
  logic [95:0]     cur_mem [est_pkg::SLOTS];
  logic [31:0]     key_rd_q, seen_rd_q;
  logic [95:0]     cur_rd_q;

  logic            out_free, probe_hit, probe_empty, key_we, seen_we, cur_we, stale_hit;
  logic            out_load;
  logic [16:0]     op_a, op_b, src_hi, src_lo;
  logic [32:0]     dmag [3];
  logic [31:0]     age;

  assign out_free    = !out_vld_q || out_ready_i;
  assign probe_hit   = occ_q[idx_q] && (key_rd_q == item_q.key);
  assign probe_empty = !occ_q[idx_q];
  assign key_we      = (state_q == S_PRB_CMP) && probe_empty;
  assign seen_we     = (state_q == S_PRB_CMP) && (probe_hit || probe_empty);
  assign cur_we      = (state_q == S_UPD);
  assign age         = tick_q - seen_rd_q;
  assign stale_hit   = p_vld_q && occ_q[p_idx_q] && (age > {24'd0, stale_i});

  assign item_pop_o = (state_q == S_IDLE) && item_valid_i &&
                      (item_i.op == est_pkg::OP_SAMPLE || item_i.op == est_pkg::OP_TICK ||
                       out_free);

  // result register loads when a clear, null-key or no-op item is taken, or when a sample or tick finishes
  assign out_load = (item_pop_o && item_i.op != est_pkg::OP_SAMPLE &&
                     item_i.op != est_pkg::OP_TICK) ||
                    ((state_q == S_FIN) && out_free);

  always_comb begin
    logic signed [32:0] dx, dy, dz;
    dx = $signed({item_q.pos_x[31], item_q.pos_x}) - $signed({cur_rd_q[31], cur_rd_q[31:0]});
    dy = $signed({item_q.pos_y[31], item_q.pos_y}) - $signed({cur_rd_q[63], cur_rd_q[63:32]});
    dz = $signed({item_q.pos_z[31], item_q.pos_z}) - $signed({cur_rd_q[95], cur_rd_q[95:64]});
    dmag[0] = dx[32] ? 33'(-dx) : 33'(dx);
    dmag[1] = dy[32] ? 33'(-dy) : 33'(dy);
    dmag[2] = dz[32] ? 33'(-dz) : 33'(dz);
  end

  always_comb begin
    case (axis_q)
      2'd0:    begin src_hi = mag_q[0][32:16]; src_lo = {1'b0, mag_q[0][15:0]}; end
      2'd1:    begin src_hi = mag_q[1][32:16]; src_lo = {1'b0, mag_q[1][15:0]}; end
      2'd2:    begin src_hi = mag_q[2][32:16]; src_lo = {1'b0, mag_q[2][15:0]}; end
      default: begin src_hi = {2'b0, thresh_i[30:16]}; src_lo = {1'b0, thresh_i[15:0]}; end
    endcase
    case (part_q)
      2'd0:    begin op_a = src_hi; op_b = src_hi; end
      2'd1:    begin op_a = src_hi; op_b = src_lo; end
      default: begin op_a = src_lo; op_b = src_lo; end
    endcase
    case (ppart_q)
      2'd0:    addend = {32'd0, prod_q} << 32;
      2'd1:    addend = {32'd0, prod_q} << 17;
      default: addend = {32'd0, prod_q};
    endcase
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[idx_q] <= item_q.key;
    key_rd_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[idx_q] <= tick_q;
    seen_rd_q <= seen_mem[scnt_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[slot_q] <= {item_q.pos_z, item_q.pos_y, item_q.pos_x};
    cur_rd_q <= cur_mem[slot_q];
  end

  // multiply datapath
  always_ff @(posedge clk_i) begin
    prod_q  <= op_a * op_b;
    ppart_q <= part_q;
    pthr_q  <= (axis_q == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      cv_q         <= '0;
      active_q     <= '0;
      tick_q       <= est_pkg::TICK_RESET;
      tcount_q     <= '0;
      pv_q         <= 1'b0;
      p_vld_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (out_load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      pv_q <= (state_q == S_MUL);
      if (pv_q) begin
        if (pthr_q) t2_q <= t2_q + addend;
        else acc_q <= acc_q + addend;
      end
      case (state_q)
        S_IDLE: begin
          if (item_pop_o) begin
            item_q      <= item_i;
            aged_q      <= '0;
            slot_q      <= '0;
            res_tp_q    <= 1'b0;
            res_ready_q <= 1'b0;
            idx_q       <= item_i.key[est_pkg::HASH_SHIFT +: IW];
            cnt_q       <= '0;
            scnt_q      <= '0;
            p_vld_q     <= 1'b0;
            case (item_i.op)
              est_pkg::OP_SAMPLE: state_q <= S_PRB_RD;
              est_pkg::OP_TICK:   state_q <= S_SWEEP;
              default: begin
                out_slot_q   <= '0;
                out_tp_q     <= 1'b0;
                out_ready_q  <= 1'b0;
                out_aged_q   <= '0;
                out_total_q  <= tcount_q;
                if (item_i.op == est_pkg::OP_CLEAR) begin
                  out_status_q <= est_pkg::ST_CLEARED;
                  out_active_q <= '0;
                  occ_q        <= '0;
                  cv_q         <= '0;
                  active_q     <= '0;
                end else if (item_i.op == est_pkg::OP_NULL) begin
                  out_status_q <= est_pkg::ST_NULL;
                  out_active_q <= 7'(active_q);
                end else begin
                  out_status_q <= est_pkg::ST_NOP;
                  out_active_q <= 7'(active_q);
                end
              end
            endcase
          end
        end
        S_PRB_RD: state_q <= S_PRB_CMP;
        S_PRB_CMP: begin
          if (probe_hit || probe_empty) begin
            slot_q       <= idx_q;
            res_status_q <= probe_empty ? est_pkg::ST_NEW : est_pkg::ST_UPDATED;
            if (probe_empty) begin
              occ_q[idx_q] <= 1'b1;
              cv_q[idx_q]  <= 1'b0;
              active_q     <= active_q + CW'(1);
            end
            state_q <= S_UPD_RD;
          end else if (cnt_q == IW'(est_pkg::SLOTS - 1)) begin
            res_status_q <= est_pkg::ST_FULL;
            state_q      <= S_FIN;
          end else begin
            idx_q   <= idx_q + IW'(1);
            cnt_q   <= cnt_q + IW'(1);
            state_q <= S_PRB_RD;
          end
        end
        S_UPD_RD: state_q <= S_UPD;
        S_UPD: begin
          cv_q[slot_q] <= 1'b1;
          mag_q[0]     <= dmag[0];
          mag_q[1]     <= dmag[1];
          mag_q[2]     <= dmag[2];
          axis_q       <= '0;
          part_q       <= '0;
          acc_q        <= '0;
          t2_q         <= '0;
          state_q      <= cv_q[slot_q] ? S_MUL : S_FIN;
        end
        S_MUL: begin
          if (part_q == 2'd2) begin
            part_q <= '0;
            axis_q <= axis_q + 2'd1;
            if (axis_q == 2'd3) state_q <= S_DRAIN;
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        S_DRAIN: state_q <= S_CMP;
        S_CMP: begin
          res_tp_q    <= (acc_q > t2_q);
          res_ready_q <= !(acc_q > t2_q);
          if (acc_q > t2_q) tcount_q <= tcount_q + 32'd1;
          state_q <= S_FIN;
        end
        S_SWEEP: begin
          p_vld_q <= (scnt_q < CW'(est_pkg::SLOTS));
          p_idx_q <= scnt_q[IW-1:0];
          if (scnt_q < CW'(est_pkg::SLOTS)) scnt_q <= scnt_q + CW'(1);
          if (stale_hit) begin
            occ_q[p_idx_q] <= 1'b0;
            cv_q[p_idx_q]  <= 1'b0;
            active_q       <= active_q - CW'(1);
            aged_q         <= aged_q + CW'(1);
          end
          if (p_vld_q && p_idx_q == IW'(est_pkg::SLOTS - 1)) begin
            tick_q       <= tick_q + 32'd1;
            res_status_q <= est_pkg::ST_TICK;
            state_q      <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_slot_q   <= 6'(slot_q);
            out_tp_q     <= res_tp_q;
            out_ready_q  <= res_ready_q;
            out_aged_q   <= 7'(aged_q);
            out_active_q <= 7'(active_q);
            out_total_q  <= tcount_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign slot_o           = out_slot_q;
  assign teleport_o       = out_tp_q;
  assign ready_res_o      = out_ready_q;
  assign aged_out_o       = out_aged_q;
  assign active_slots_o   = out_active_q;
  assign teleport_total_o = out_total_q;

endmodule

`default_nettype wire

@@ rtl/entity_slot_tracker_core.sv @@
// entity_slot_tracker_core: top level with configuration registers
// depends on est_pkg, est_front, est_back
`default_nettype none

// Tracks up to 64 entities in an open-addressed table with linear probing.
// Items enter a two-beat queue and are carried out one at a time by the
// engine. A sample reads the key memory and then compares for each probed
// slot, then reads and writes the update; when the slot already holds a
// position it goes on to one 17x17 multiplier stepping through 12 partial
// products of the squared displacement and squared threshold, then a drain
// and a compare step, and last it loads the result. An end-of-tick sweep
// reads last-seen stamps one slot per cycle. Clear, null-key and disabled
// items load the result register as they are taken. The result register
// lets the next sample or tick start while a result waits to be taken.
module entity_slot_tracker_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [31:0]         key_i,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               status_o,
  output logic [5:0]               slot_o,
  output logic                     teleport_o,
  output logic                     ready_res_o,
  output logic [6:0]               aged_out_o,
  output logic [6:0]               active_slots_o,
  output logic [31:0]              teleport_total_o
);

  logic           enable_q;
  logic [30:0]    thresh_q;
  logic [7:0]     stale_q;
  logic           item_valid, item_pop;
  est_pkg::item_t item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      thresh_q <= est_pkg::THRESH_RESET;
      stale_q  <= est_pkg::STALE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        est_pkg::CFG_ENABLE: enable_q <= cfg_data_i[0];
        est_pkg::CFG_THRESH: thresh_q <= cfg_data_i[30:0];
        est_pkg::CFG_STALE:  stale_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  est_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  est_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .item_pop_o       (item_pop),
    .thresh_i         (thresh_q),
    .stale_i          (stale_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .teleport_o       (teleport_o),
    .ready_res_o      (ready_res_o),
    .aged_out_o       (aged_out_o),
    .active_slots_o   (active_slots_o),
    .teleport_total_o (teleport_total_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench of the entity slot tracker core
// depends on est_pkg and entity_slot_tracker_core; predicts every result beat
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int SLOTS = est_pkg::SLOTS;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        teleport;
    logic        ready_res;
    logic [6:0]  aged_out;
    logic [6:0]  active_slots;
    logic [31:0] teleport_total;
  } res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] px, py, pz;
    bit          typed;
    res_t        res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [31:0] key_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [5:0] slot_o;
  logic teleport_o, ready_res_o;
  logic [6:0] aged_out_o, active_slots_o;
  logic [31:0] teleport_total_o;

  entity_slot_tracker_core DUT (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] tab_key [SLOTS];
  logic [31:0] tab_seen [SLOTS];
  logic [31:0] tab_cx [SLOTS], tab_cy [SLOTS], tab_cz [SLOTS];
  logic [31:0] tab_px [SLOTS], tab_py [SLOTS], tab_pz [SLOTS];
  bit tab_cv [SLOTS], tab_pv [SLOTS], tab_tf [SLOTS];
  logic [31:0] tick_now, tp_count;
  bit en_r;
  logic [30:0] thresh_r;
  logic [7:0] stale_r;

  res_t pending_res [$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  int n_teleports_seen = 0;
  int cycle = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit recv_hold = 0;

  function automatic void free_entry(int i);
    tab_key[i] = '0; tab_seen[i] = '0;
    tab_cx[i] = '0; tab_cy[i] = '0; tab_cz[i] = '0;
    tab_px[i] = '0; tab_py[i] = '0; tab_pz[i] = '0;
    tab_cv[i] = 0; tab_pv[i] = 0; tab_tf[i] = 0;
  endfunction

  function automatic logic [65:0] dist_sq(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 33'(-d) : 33'(d);
    return 66'(m) * 66'(m);
  endfunction

  function automatic res_t track_item(logic [1:0] mode, logic [31:0] key,
                                      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    res_t r;
    int home, idx, cnt;
    bit found;
    logic [67:0] acc;
    r = '0;
    r.status = est_pkg::ST_NOP;
    if (mode == est_pkg::MODE_SAMPLE && en_r) begin
      if (key == 0) begin
        r.status = est_pkg::ST_NULL;
      end else begin
        home = int'((key >> est_pkg::HASH_SHIFT) % SLOTS);
        found = 0;
        r.status = est_pkg::ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          idx = (home + i) % SLOTS;
          if (tab_key[idx] == key) begin
            r.slot = 6'(idx); r.status = est_pkg::ST_UPDATED; found = 1; break;
          end
          if (tab_key[idx] == 0) begin
            free_entry(idx); tab_key[idx] = key;
            r.slot = 6'(idx); r.status = est_pkg::ST_NEW; found = 1; break;
          end
        end
        if (found) begin
          idx = int'(r.slot);
          tab_seen[idx] = tick_now;
          if (tab_cv[idx]) begin
            tab_px[idx] = tab_cx[idx]; tab_py[idx] = tab_cy[idx];
            tab_pz[idx] = tab_cz[idx]; tab_pv[idx] = 1;
          end
          tab_cx[idx] = px; tab_cy[idx] = py; tab_cz[idx] = pz; tab_cv[idx] = 1;
          if (tab_pv[idx]) begin
            acc = 68'(dist_sq(px, tab_px[idx])) + 68'(dist_sq(py, tab_py[idx]))
                + 68'(dist_sq(pz, tab_pz[idx]));
            tab_tf[idx] = acc > 68'(64'(thresh_r) * 64'(thresh_r));
            if (tab_tf[idx]) begin
              tp_count++; r.teleport = 1;
            end
          end
          r.ready_res = tab_pv[idx] && tab_cv[idx] && !tab_tf[idx];
        end
      end
    end else if (mode == est_pkg::MODE_TICK && en_r) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (tab_key[i] != 0 && (tick_now - tab_seen[i]) > 32'(stale_r)) begin
          free_entry(i); r.aged_out++;
        end
      end
      tick_now++;
      r.status = est_pkg::ST_TICK;
    end else if (mode == est_pkg::MODE_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) free_entry(i);
      r.status = est_pkg::ST_CLEARED;
    end
    cnt = 0;
    for (int i = 0; i < SLOTS; i++) if (tab_key[i] != 0) cnt++;
    r.active_slots = 7'(cnt);
    r.teleport_total = tp_count;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= index; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      est_pkg::CFG_ENABLE: en_r = data[0];
      est_pkg::CFG_THRESH: thresh_r = data[30:0];
      default:             stale_r = data[7:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_empty();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // typed rows carry a known result; others get the predictor's value
  task automatic send_item(logic [1:0] mode, logic [31:0] key, logic [31:0] px,
                           logic [31:0] py, logic [31:0] pz, bit typed = 0,
                           res_t typed_res = '0);
    res_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; mode_i <= mode; key_i <= key;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    r = track_item(mode, key, px, py, pz);
    if (typed) pending_res.push_back(typed_res);
    else pending_res.push_back(r);
    n_items++;
  endtask

  function automatic logic [31:0] key_for(int home, int salt);
    return {salt[21:0], home[5:0], 4'(salt)};
  endfunction

  function automatic logic [31:0] rand_pos(logic [31:0] base);
    case ($urandom_range(4))
      0: return $urandom;
      1: return base + $urandom_range(65536 * 20) - 32'(65536 * 10);
      2: return {1'($urandom_range(1)), 31'd0};
      default: return base + $urandom_range(2048) - 32'd1024;
    endcase
  endfunction

  // receiver
  always @(posedge clk_i) begin
    res_t got, want;
    cycle <= cycle + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, slot_o, teleport_o, ready_res_o, aged_out_o,
             active_slots_o, teleport_total_o};
      n_results++;
      if (got.teleport) n_teleports_seen++;
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.slot != want.slot) begin
          $error("slot exp %0d got %0d", want.slot, got.slot); errors++;
        end
        if (got.teleport != want.teleport) begin
          $error("teleport exp %0d got %0d", want.teleport, got.teleport); errors++;
        end
        if (got.ready_res != want.ready_res) begin
          $error("ready_res exp %0d got %0d", want.ready_res, got.ready_res); errors++;
        end
        if (got.aged_out != want.aged_out) begin
          $error("aged_out exp %0d got %0d", want.aged_out, got.aged_out); errors++;
        end
        if (got.active_slots != want.active_slots) begin
          $error("active_slots exp %0d got %0d", want.active_slots, got.active_slots);
          errors++;
        end
        if (got.teleport_total != want.teleport_total) begin
          $error("teleport_total exp %0d got %0d", want.teleport_total,
                 got.teleport_total);
          errors++;
        end
      end
    end
    out_ready_i <= !recv_hold && !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycle >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic random_phase(int count);
    logic [31:0] keys [16];
    logic [31:0] k, base;
    int pick, slot_pick;
    for (int i = 0; i < 16; i++) keys[i] = key_for($urandom_range(7), $urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        k = (pick < 3) ? 32'h0 : (pick < 8) ? $urandom : keys[$urandom_range(15)];
        base = $urandom_range(255) << 16;
        send_item(est_pkg::MODE_SAMPLE, k, rand_pos(base), rand_pos(base), rand_pos(base));
      end else if (pick < 92) begin
        send_item(est_pkg::MODE_TICK, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 94) begin
        send_item(est_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 96) begin
        send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // fresh key in a crowded neighborhood
        slot_pick = $urandom_range(15);
        keys[slot_pick] = key_for($urandom_range(3), $urandom);
        send_item(est_pkg::MODE_SAMPLE, keys[slot_pick], $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    row_t rows [$];
    row_t rw;
    res_t nop_res;
    for (int i = 0; i < SLOTS; i++) free_entry(i);
    tick_now = est_pkg::TICK_RESET; tp_count = '0;
    en_r = 0; thresh_r = est_pkg::THRESH_RESET; stale_r = est_pkg::STALE_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset: everything but clear is a no-op
    nop_res = '0; nop_res.status = est_pkg::ST_NOP;
    rw = '{est_pkg::MODE_SAMPLE, 32'h10, 0, 0, 0, 1, nop_res}; rows.push_back(rw);
    rw = '{est_pkg::MODE_TICK, 32'h0, 0, 0, 0, 1, nop_res}; rows.push_back(rw);
    rw = '{2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, nop_res};
    rows.push_back(rw);
    rw = '{est_pkg::MODE_CLEAR, 32'h0, 0, 0, 0, 1, '0}; rw.res.status = est_pkg::ST_CLEARED;
    rows.push_back(rw);
    foreach (rows[i])
      send_item(rows[i].mode, rows[i].key, rows[i].px, rows[i].py, rows[i].pz,
                rows[i].typed, rows[i].res);
    wait_empty();

    write_reg(est_pkg::CFG_ENABLE, 32'h1);
    rows.delete();
    rw = '{est_pkg::MODE_SAMPLE, 32'h0, 0, 0, 0, 1, '0}; rw.res.status = est_pkg::ST_NULL;
    rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h10, 32'h80000000, 32'h7fffffff, 32'h0, 1, '0};
    rw.res.status = est_pkg::ST_NEW; rw.res.slot = 1; rw.res.active_slots = 1;
    rows.push_back(rw);
    // extreme jump: squared sum overflows 64 bits
    rw = '{est_pkg::MODE_SAMPLE, 32'h10, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, '0};
    rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h10, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, '0};
    rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'hffffffff, 32'h1, 32'h2, 32'h3, 0, '0}; rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h3f0, 32'h5, 32'h5, 32'h5, 0, '0}; rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h3f1, 32'h5, 32'h5, 32'h5, 0, '0}; rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h3f0, 32'ha0005, 32'h5, 32'h5, 0, '0}; rows.push_back(rw);
    rw = '{est_pkg::MODE_SAMPLE, 32'h3f0, 32'h140006, 32'h5, 32'h5, 0, '0}; rows.push_back(rw);
    for (int i = 0; i < 8; i++) begin
      rw = '{est_pkg::MODE_TICK, 32'h0, 0, 0, 0, 0, '0}; rows.push_back(rw);
    end
    foreach (rows[i])
      send_item(rows[i].mode, rows[i].key, rows[i].px, rows[i].py, rows[i].pz,
                rows[i].typed, rows[i].res);
    wait_empty();

    // fill the whole table, then one more key
    write_reg(est_pkg::CFG_STALE, 32'hff);
    for (int i = 0; i < SLOTS; i++)
      send_item(est_pkg::MODE_SAMPLE, key_for(i, i + 1), $urandom, $urandom, $urandom);
    send_item(est_pkg::MODE_SAMPLE, 32'hdead_beef, 0, 0, 0);
    send_item(est_pkg::MODE_SAMPLE, key_for(5, 6), 0, 0, 0);
    wait_empty();

    // receiver holds off while items keep coming
    fork
      begin
        recv_hold = 1;
        repeat (600) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int i = 0; i < 12; i++)
        send_item(est_pkg::MODE_SAMPLE, key_for(i, 99), $urandom, $urandom, $urandom);
    join
    send_item(est_pkg::MODE_CLEAR, 0, 0, 0, 0);
    wait_empty();

    write_reg(est_pkg::CFG_THRESH, 32'h0);
    write_reg(est_pkg::CFG_STALE, 32'h0);
    send_idle_pct = 38; recv_idle_pct = 76;
    random_phase(500);
    wait_empty();

    write_reg(est_pkg::CFG_THRESH, 32'h7fffffff);
    write_reg(est_pkg::CFG_STALE, 32'd3);
    send_idle_pct = 76; recv_idle_pct = 38;
    random_phase(500);
    wait_empty();

    write_reg(est_pkg::CFG_THRESH, 32'd655360);
    write_reg(est_pkg::CFG_STALE, 32'd1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(450);
    wait_empty();
    write_reg(est_pkg::CFG_ENABLE, 32'h0);
    random_phase(40);
    wait_empty();

    $display("ran %0d items, checked %0d results, %0d teleports flagged",
             n_items, n_results, n_teleports_seen);
    $display("covered disabled, null, full table, age-out, clear and threshold extremes");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
